@@ hw/rtl/prfs_pkg.sv @@
`timescale 1ns / 1ps

package prfs_pkg;

   // Design constants.
   localparam int MAX_SIDE        = 4096;
   localparam int SINE_TABLE_BITS = 10;
   localparam int QUEUE_DEPTH     = 4;

   // Fixed field widths.
   localparam int SAMPLE_W = 16;
   localparam int SIDE_W   = 13;
   localparam int PHASE_W  = 32;
   localparam int CSR_W    = 32;
   localparam int CSR_IDX_W = 2;

   // Derived widths.
   localparam int CNT_W   = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
   localparam int IDX_W   = SINE_TABLE_BITS;
   localparam int R_W     = SINE_TABLE_BITS - 1;
   localparam int QUARTER = 1 << (SINE_TABLE_BITS - 2);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W  = QPTR_W + 1;

   // Register indexes of the configuration port.
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SIDE_LEN = 2'd0,
      REG_STEP_X   = 2'd1,
      REG_STEP_Y   = 2'd2
   } reg_index_type;

   // One item as it travels from the front end to the back end.
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample_re;
      logic signed [SAMPLE_W-1:0] sample_im;
      logic [IDX_W-1:0]           sine_idx;
      logic                       frame_end;
   } item_type;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] ONE_Q30     = 64'd1 << 30;

   // Quarter-wave sine magnitude in Q1.15, from a truncated Taylor series
   // evaluated in Horner form. Used only at elaboration to build the table.
   function automatic logic [14:0] quarter_sine(input int unsigned r);
      logic [63:0] a;
      logic [63:0] x2;
      logic [63:0] t;
      logic [63:0] s;
      logic [63:0] m;
      a  = (64'(r) * HALF_PI_Q30 + (64'd1 << (SINE_TABLE_BITS - 3)))
           >> (SINE_TABLE_BITS - 2);
      x2 = (a * a) >> 30;
      t  = ONE_Q30;
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd156);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd110);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd72);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd42);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd20);
      t  = ONE_Q30 - (((x2 * t) >> 30) / 64'd6);
      s  = (a * t) >> 30;
      m  = (s + (64'd1 << 14)) >> 15;
      if (m > 64'd32767) begin
         m = 64'd32767;
      end
      return m[14:0];
   endfunction

   typedef logic [14:0] sine_tab_type [0:QUARTER];

   function automatic sine_tab_type build_sine_tab();
      sine_tab_type tab;
      for (int i = 0; i <= QUARTER; i++) begin
         tab[i] = quarter_sine(i);
      end
      return tab;
   endfunction

   // Quarter-wave table, entries 0 through QUARTER inclusive.
   localparam sine_tab_type SINE_TAB = build_sine_tab();

endpackage

@@ hw/rtl/prfs_front.sv @@
`timescale 1ns / 1ps

module prfs_front
   import prfs_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic [SIDE_W-1:0]          side_len,
   input  logic [PHASE_W-1:0]         step_x,
   input  logic [PHASE_W-1:0]         step_y,
   input  logic                       accept,
   input  logic signed [SAMPLE_W-1:0] sample_re,
   input  logic signed [SAMPLE_W-1:0] sample_im,
   output item_type                   item
);

   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [PHASE_W-1:0] row_phase_ff, row_phase_in;
   logic [PHASE_W-1:0] pix_phase_ff, pix_phase_in;
   logic [CNT_W-1:0]   side_m1;
   logic               row_end;
   logic               last;

   // Side length zero acts as one; anything above the maximum is clamped.
   always_comb begin
      if (side_len == '0) begin
         side_m1 = '0;
      end else if (32'(side_len) > 32'(MAX_SIDE)) begin
         side_m1 = CNT_W'(MAX_SIDE - 1);
      end else begin
         side_m1 = CNT_W'(side_len - SIDE_W'(1));
      end
   end

   assign row_end = (col_ff >= side_m1);
   assign last    = row_end && (row_ff >= side_m1);

   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      row_phase_in = row_phase_ff;
      pix_phase_in = pix_phase_ff;
      if (accept) begin
         if (last) begin
            col_in       = '0;
            row_in       = '0;
            row_phase_in = '0;
            pix_phase_in = '0;
         end else if (row_end) begin
            col_in       = '0;
            row_in       = row_ff + CNT_W'(1);
            row_phase_in = row_phase_ff + step_y;
            pix_phase_in = row_phase_ff + step_y;
         end else begin
            col_in       = col_ff + CNT_W'(1);
            pix_phase_in = pix_phase_ff + step_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff       <= '0;
         row_ff       <= '0;
         row_phase_ff <= '0;
         pix_phase_ff <= '0;
      end else begin
         col_ff       <= col_in;
         row_ff       <= row_in;
         row_phase_ff <= row_phase_in;
         pix_phase_ff <= pix_phase_in;
      end
   end

   always_comb begin
      item.sample_re = sample_re;
      item.sample_im = sample_im;
      item.sine_idx  = pix_phase_ff[PHASE_W-1 -: IDX_W];
      item.frame_end = last;
   end

endmodule

@@ hw/rtl/prfs_queue.sv @@
`timescale 1ns / 1ps

module prfs_queue
   import prfs_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     wr_en,
   input  item_type wr_item,
   output logic     is_full,
   input  logic     rd_en,
   output item_type rd_item,
   output logic     rd_valid
);

   item_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_wr;
   logic              do_rd;

   assign is_full  = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_item  = entry_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !is_full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? QPTR_W'(wr_ptr_ff + QPTR_W'(1)) : wr_ptr_ff;
      rd_ptr_in = do_rd ? QPTR_W'(rd_ptr_ff + QPTR_W'(1)) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

@@ hw/rtl/prfs_back.sv @@
`timescale 1ns / 1ps

module prfs_back
   import prfs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  item_type                    head,
   input  logic                        head_valid,
   output logic                        head_take,
   output logic signed [SAMPLE_W-1:0]  rotated_re,
   output logic signed [SAMPLE_W-1:0]  rotated_im,
   output logic                        frame_end,
   output logic                        is_empty,
   input  logic                        take
);

   // Signed sine from the quarter-wave table using quadrant symmetry.
   function automatic logic signed [SAMPLE_W-1:0] sine_of(input logic [IDX_W-1:0] idx);
      logic [1:0]     quad;
      logic [R_W-1:0] r;
      logic [14:0]    mag;
      quad = idx[IDX_W-1 -: 2];
      r    = R_W'(idx[IDX_W-3:0]);
      if (quad[0]) begin
         r = R_W'(QUARTER) - r;
      end
      mag = SINE_TAB[r];
      return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   // Round half up by 2^15, then saturate to 16 bits.
   function automatic logic signed [SAMPLE_W-1:0] round_sat(input logic signed [32:0] v);
      logic signed [33:0] biased;
      logic signed [18:0] q;
      biased = $signed({v[32], v}) + 34'sd16384;
      q      = biased[33:15];
      if (q > 19'sd32767) begin
         return 16'sh7fff;
      end else if (q < -19'sd32768) begin
         return 16'sh8000;
      end
      return q[15:0];
   endfunction

   // Stage 1: table lookup.
   logic                       v1_ff;
   logic signed [SAMPLE_W-1:0] s1_re_ff, s1_im_ff, s1_sn_ff, s1_cs_ff;
   logic                       s1_last_ff;
   // Stage 2: products.
   logic                       v2_ff;
   logic signed [31:0]         p_rc_ff, p_is_ff, p_rs_ff, p_ic_ff;
   logic                       s2_last_ff;
   // Stage 3: output register.
   logic                       v3_ff;
   logic signed [SAMPLE_W-1:0] o_re_ff, o_im_ff;
   logic                       o_last_ff;

   logic               ready1, ready2, ready3;
   logic [IDX_W-1:0]   cos_idx;
   logic signed [32:0] sum_re, sum_im;

   assign ready3    = !v3_ff || take;
   assign ready2    = !v2_ff || ready3;
   assign ready1    = !v1_ff || ready2;
   assign head_take = head_valid && ready1;

   assign cos_idx = head.sine_idx + IDX_W'(QUARTER);
   assign sum_re  = $signed({p_rc_ff[31], p_rc_ff}) - $signed({p_is_ff[31], p_is_ff});
   assign sum_im  = $signed({p_rs_ff[31], p_rs_ff}) + $signed({p_ic_ff[31], p_ic_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= head_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (head_take) begin
         s1_re_ff   <= head.sample_re;
         s1_im_ff   <= head.sample_im;
         s1_sn_ff   <= sine_of(head.sine_idx);
         s1_cs_ff   <= sine_of(cos_idx);
         s1_last_ff <= head.frame_end;
      end
      if (v1_ff && ready2) begin
         p_rc_ff    <= s1_re_ff * s1_cs_ff;
         p_is_ff    <= s1_im_ff * s1_sn_ff;
         p_rs_ff    <= s1_re_ff * s1_sn_ff;
         p_ic_ff    <= s1_im_ff * s1_cs_ff;
         s2_last_ff <= s1_last_ff;
      end
      if (v2_ff && ready3) begin
         o_re_ff   <= round_sat(sum_re);
         o_im_ff   <= round_sat(sum_im);
         o_last_ff <= s2_last_ff;
      end
   end

   assign rotated_re = o_re_ff;
   assign rotated_im = o_im_ff;
   assign frame_end  = o_last_ff;
   assign is_empty   = !v3_ff;

endmodule

@@ hw/rtl/phase_ramp_fourier_shift.sv @@
`timescale 1ns / 1ps

// Phase-ramp mixer for a two-dimensional Fourier shift. Complex Q1.15
// samples of a square N-by-N image enter in raster order on the request
// queue: an item is taken at a clock edge where push is high and full is
// low. Each sample is rotated by the phase x*step_x + y*step_y (turns
// scaled by 2^32), using a quarter-wave sine table, then rounded and
// saturated to Q1.15. Results leave through the response queue: the
// oldest result is shown while empty is low and is taken when pop is high.
// The last pixel of each frame carries frame_end.
// An item passes a queue entry and the lookup, product and output
// registers; one item is taken every cycle while full is low. The front end
// (pixel counters and phase accumulators) writes into a four-entry queue;
// the back end (table lookup, four multipliers, round and saturate) drains
// it. When pop stays low the back end holds its results, the queue fills,
// and full rises after a few further items. Reset returns the side length
// to 256, both steps to zero, clears the counters and phases and empties
// every stage. The user must write the configuration registers only while
// no item is in flight; the block itself does not enforce this.
module phase_ramp_fourier_shift
   import prfs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   output logic                        full,
   input  logic signed [SAMPLE_W-1:0]  req_sample_re,
   input  logic signed [SAMPLE_W-1:0]  req_sample_im,
   output logic                        empty,
   input  logic                        pop,
   output logic signed [SAMPLE_W-1:0]  rsp_rotated_re,
   output logic signed [SAMPLE_W-1:0]  rsp_rotated_im,
   output logic                        rsp_frame_end,
   input  logic                        csr_we,
   input  logic [CSR_IDX_W-1:0]        csr_index,
   input  logic [CSR_W-1:0]            csr_wdata
);

   logic [SIDE_W-1:0]  side_len_ff;
   logic [PHASE_W-1:0] step_x_ff;
   logic [PHASE_W-1:0] step_y_ff;

   logic     q_full;
   logic     accept;
   item_type front_item;
   item_type head_item;
   logic     head_valid;
   logic     head_take;

   // Configuration registers; writes to an unused index are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         side_len_ff <= SIDE_W'(256);
         step_x_ff   <= '0;
         step_y_ff   <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_SIDE_LEN: side_len_ff <= csr_wdata[SIDE_W-1:0];
            REG_STEP_X:   step_x_ff   <= csr_wdata[PHASE_W-1:0];
            REG_STEP_Y:   step_y_ff   <= csr_wdata[PHASE_W-1:0];
            default:      ;
         endcase
      end
   end

   assign full   = q_full;
   assign accept = push && !q_full;

   prfs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .side_len  (side_len_ff),
      .step_x    (step_x_ff),
      .step_y    (step_y_ff),
      .accept    (accept),
      .sample_re (req_sample_re),
      .sample_im (req_sample_im),
      .item      (front_item)
   );

   prfs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_item  (front_item),
      .is_full  (q_full),
      .rd_en    (head_take),
      .rd_item  (head_item),
      .rd_valid (head_valid)
   );

   prfs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head_item),
      .head_valid (head_valid),
      .head_take  (head_take),
      .rotated_re (rsp_rotated_re),
      .rotated_im (rsp_rotated_im),
      .frame_end  (rsp_frame_end),
      .is_empty   (empty),
      .take       (pop)
   );

endmodule
